// ===== rtl/core/lpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpp_pkg: shared types and constants of the lottery process picker
// Table geometry, field widths, request modes, sequencer states and the
// request/response structs of the shared add/subtract unit.
// ----------------------------------------------------------------------------
package lpp_pkg;

	// Table geometry
	localparam int ENTRY_COUNT = 16;
	localparam int TICKET_BITS = 16;
	localparam int IDX_BITS    = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int TOTAL_BITS  = TICKET_BITS + IDX_BITS;
	localparam int ALU_BITS    = TOTAL_BITS + 1;

	// Fixed port field widths
	localparam int IN_IDX_BITS     = 4;
	localparam int IN_TICKET_BITS  = 16;
	localparam int RAND_BITS       = 32;
	localparam int OUT_IDX_BITS    = 4;
	localparam int OUT_TOTAL_BITS  = 20;
	localparam int STEP_BITS       = $clog2(RAND_BITS);

	// Last values of the sequencer counters
	localparam logic [IDX_BITS-1:0]  CNT_LAST  = IDX_BITS'(ENTRY_COUNT - 1);
	localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(RAND_BITS - 1);

	// Request modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_DRAW  = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MOD,
		ST_PICK,
		ST_FINISH
	} lpp_state_t;

	// One table entry
	typedef struct packed {
		logic                   runnable;
		logic [TICKET_BITS-1:0] tickets;
	} lpp_entry_t;

	// Shared add/subtract unit operands and result
	typedef struct packed {
		logic                sub;
		logic [ALU_BITS-1:0] a;
		logic [ALU_BITS-1:0] b;
	} lpp_alu_req_t;

	typedef struct packed {
		logic                carry;
		logic [ALU_BITS-1:0] res;
	} lpp_alu_rsp_t;

endpackage

// ===== rtl/core/lpp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpp_if: request and response channels of the lottery process picker
// Valid/ready channels; a request or response moves when both are high.
// ----------------------------------------------------------------------------
interface lpp_req_if
	import lpp_pkg::*;
	();
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [IN_IDX_BITS-1:0]    entry_index;
	logic [IN_TICKET_BITS-1:0] entry_tickets;
	logic                      entry_runnable;
	logic [RAND_BITS-1:0]      random_word;

	modport source (
		output valid, mode, entry_index, entry_tickets, entry_runnable, random_word,
		input  ready
	);
	modport sink (
		input  valid, mode, entry_index, entry_tickets, entry_runnable, random_word,
		output ready
	);
endinterface

interface lpp_rsp_if
	import lpp_pkg::*;
	();
	logic                      valid;
	logic                      ready;
	logic [OUT_IDX_BITS-1:0]   winner_index;
	logic [OUT_TOTAL_BITS-1:0] total_tickets;
	logic                      winner_valid;

	modport source (
		output valid, winner_index, total_tickets, winner_valid,
		input  ready
	);
	modport sink (
		input  valid, winner_index, total_tickets, winner_valid,
		output ready
	);
endinterface

// ===== rtl/core/lpp_addsub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpp_addsub: shared add/subtract unit
// Adds or subtracts two operands; carry out of a subtract means no borrow.
// ----------------------------------------------------------------------------
module lpp_addsub
	import lpp_pkg::*;
(
	input  lpp_alu_req_t op,
	output lpp_alu_rsp_t result
);

	logic [ALU_BITS:0] sum;

	// Add b, or add its two's complement to subtract
	always_comb begin
		sum = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + (ALU_BITS + 1)'(op.sub);
		result.carry = sum[ALU_BITS];
		result.res   = sum[ALU_BITS-1:0];
	end

endmodule

// ===== rtl/core/lpp_entry_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpp_entry_table: ticket counts and runnable flags of all entries
// One write port from the request side, one read port at the walk counter.
// ----------------------------------------------------------------------------
module lpp_entry_table
	import lpp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IDX_BITS-1:0] wr_addr,
	input  lpp_entry_t          wr_data,
	input  logic [IDX_BITS-1:0] rd_addr,
	output lpp_entry_t          rd_data
);

	lpp_entry_t entry_q [ENTRY_COUNT];

	// Store one entry; reset clears all tickets and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				entry_q[i] <= '0;
			end
		end else if (wr_en) begin
			entry_q[wr_addr] <= wr_data;
		end
	end

	// Read the entry under the walk counter
	assign rd_data = entry_q[rd_addr];

endmodule

// ===== rtl/core/lottery_process_picker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lottery_process_picker_unit: lottery scheduler over a table of entries
// Write requests set one entry; draw requests pick a winner by lottery.
// ----------------------------------------------------------------------------
// A write request (mode 0) stores one entry's ticket count and runnable flag and
// gives no response; an index beyond the table is dropped. A draw request (mode 1)
// gives one response: it sums the tickets of the runnable entries, reduces the
// random word modulo that total one bit per cycle, walks the entries to the
// winner and loads the response register. All steps share a single
// add/subtract unit, so the block takes no new request until the draw is done.
// A zero total gives winner_valid low, total_tickets zero and the current entry
// as winner_index; the current entry then stays as it is. A finished response
// waits in its register while the next request is accepted.
// ----------------------------------------------------------------------------
module lottery_process_picker_unit
	import lpp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	lpp_req_if.sink   req,
	lpp_rsp_if.source rsp
);

	lpp_state_t              state_q, state_n;
	logic [IDX_BITS-1:0]     cnt_q;
	logic [STEP_BITS-1:0]    step_q;
	logic [TOTAL_BITS-1:0]   total_q;
	logic [TOTAL_BITS-1:0]   rem_q;
	logic [RAND_BITS-1:0]    rnd_q;
	logic [IDX_BITS-1:0]     cur_q;
	logic                    rsp_valid_q;
	logic [OUT_IDX_BITS-1:0] rsp_index_q;
	logic [OUT_TOTAL_BITS-1:0] rsp_total_q;
	logic                    rsp_win_q;

	lpp_alu_req_t alu_op;
	lpp_alu_rsp_t alu_res;
	lpp_entry_t   ent;
	lpp_entry_t   wr_data;
	logic         req_fire;
	logic         wr_en;
	logic         rsp_load;
	logic         sum_zero;
	logic         pick_hit;

	// Entry table and shared arithmetic
	assign wr_data.runnable = req.entry_runnable;
	assign wr_data.tickets  = TICKET_BITS'(req.entry_tickets);
	assign req_fire = req.valid && req.ready;
	assign wr_en    = req_fire && (req.mode == MODE_WRITE)
		&& (32'(req.entry_index) < ENTRY_COUNT);

	lpp_entry_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (IDX_BITS'(req.entry_index)),
		.wr_data (wr_data),
		.rd_addr (cnt_q),
		.rd_data (ent)
	);

	lpp_addsub u_addsub (
		.op     (alu_op),
		.result (alu_res)
	);

	assign sum_zero = (alu_res.res[TOTAL_BITS-1:0] == '0);
	assign pick_hit = ent.runnable && !alu_res.carry;
	assign rsp_load = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire && (req.mode == MODE_DRAW)) state_n = ST_SUM;
			end
			ST_SUM: begin
				if (cnt_q == CNT_LAST) state_n = sum_zero ? ST_FINISH : ST_MOD;
			end
			ST_MOD: begin
				if (step_q == STEP_LAST) state_n = ST_PICK;
			end
			ST_PICK: begin
				if (pick_hit || (cnt_q == CNT_LAST)) state_n = ST_FINISH;
			end
			ST_FINISH: begin
				if (rsp_load) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and unit operands
	always_comb begin
		req.ready  = (state_q == ST_IDLE);
		alu_op.sub = 1'b0;
		alu_op.a   = '0;
		alu_op.b   = '0;
		unique case (state_q)
			ST_SUM: begin
				alu_op.a = ALU_BITS'(total_q);
				alu_op.b = ent.runnable ? ALU_BITS'(ent.tickets) : '0;
			end
			ST_MOD: begin
				alu_op.sub = 1'b1;
				alu_op.a   = {rem_q, rnd_q[RAND_BITS-1]};
				alu_op.b   = ALU_BITS'(total_q);
			end
			ST_PICK: begin
				alu_op.sub = 1'b1;
				alu_op.a   = ALU_BITS'(rem_q);
				alu_op.b   = ALU_BITS'(ent.tickets);
			end
			ST_IDLE, ST_FINISH: begin
				alu_op.sub = 1'b0;
			end
			default: alu_op.sub = 1'b0;
		endcase
	end

	// Hold state and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
			cur_q   <= '0;
		end else begin
			state_q <= state_n;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					step_q <= '0;
				end
				ST_SUM: begin
					cnt_q  <= cnt_q + 1'b1;
					step_q <= '0;
				end
				ST_MOD: begin
					cnt_q  <= '0;
					step_q <= step_q + 1'b1;
				end
				ST_PICK: begin
					cnt_q <= cnt_q + 1'b1;
					if (pick_hit) cur_q <= cnt_q;
				end
				ST_FINISH: begin
					cnt_q <= '0;
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	// Advance the datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				total_q <= '0;
				rem_q   <= '0;
				if (req_fire) rnd_q <= req.random_word;
			end
			ST_SUM: begin
				total_q <= alu_res.res[TOTAL_BITS-1:0];
				rem_q   <= '0;
			end
			ST_MOD: begin
				// Restoring reduction: keep the difference when it did not borrow
				rem_q <= alu_res.carry ? alu_res.res[TOTAL_BITS-1:0] : alu_op.a[TOTAL_BITS-1:0];
				rnd_q <= {rnd_q[RAND_BITS-2:0], 1'b0};
			end
			ST_PICK: begin
				if (ent.runnable && alu_res.carry) rem_q <= alu_res.res[TOTAL_BITS-1:0];
			end
			ST_FINISH: begin
				rem_q <= rem_q;
			end
			default: rem_q <= rem_q;
		endcase
	end

	// Hold the response until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_index_q <= OUT_IDX_BITS'(cur_q);
			rsp_total_q <= OUT_TOTAL_BITS'(total_q);
			rsp_win_q   <= (total_q != '0);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.winner_index  = rsp_index_q;
	assign rsp.total_tickets = rsp_total_q;
	assign rsp.winner_valid  = rsp_win_q;

endmodule
